FILE: rtl/flrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash record rotation controller package
// Constants, command and operation codes and the result type.
// ----------------------------------------------------------------------------
package flrc_pkg;

  localparam int SECTOR_BYTES = 4096;

  localparam int FIRST_W  = 10;
  localparam int COUNT_W  = 9;
  localparam int RECORD_W = 12;
  localparam int SEC_W    = 11;
  localparam int SLOT_W   = 13;
  localparam int OFFSET_W = $clog2(SECTOR_BYTES + 4224);
  localparam int ADDR_W   = 22;
  localparam int CMD_W    = 3;
  localparam int OP_W     = 2;
  localparam int PHASE_W  = 2;
  localparam int PADDR_W  = 4;

  localparam logic [OP_W-1:0] OP_START    = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE   = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT   = 2'd2;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

  localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DONE  = 3'd4;

  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_SCAN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_UPD  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LOOK = 2'd3;

  localparam logic [1:0] REG_FIRST  = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_RECORD = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
  } res_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SEC_W-1:0] sec,
                                                   input logic [OFFSET_W-1:0] off);
    logic [31:0] full;
    full = 32'(sec) * 32'(SECTOR_BYTES) + 32'(off);
    return full[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/flash_record_rotation_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash record rotation controller
// Keeps fixed-size records in a ring of flash sectors by issuing flash
// commands and taking slot-read reports.
// ----------------------------------------------------------------------------
// Each input transaction is decided combinationally and its zero to three flash
// commands are loaded into a three-entry result queue, which drains at one
// command per cycle while out_tready is high. A new input transaction is taken
// whenever the queue is empty or holds its final command that is being taken in
// the same cycle, so with out_tready high the sustained rate is one input per
// cycle for inputs causing at most one command, otherwise one input per command.
module flash_record_rotation_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // read_ok, slot_blank, crc_match
  input  logic [flrc_pkg::OP_W-1:0]     in_tuser,   // operation
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,  // address
  output logic [flrc_pkg::CMD_W-1:0]    out_tuser,  // command
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [flrc_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import flrc_pkg::*;

  logic [FIRST_W-1:0]  first_r;
  logic [COUNT_W-1:0]  count_r;
  logic [RECORD_W-1:0] record_r;
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  res_t                q_r [3];
  res_t                res [3];
  logic [1:0]          cnt_r, k;

  logic [SLOT_W-1:0]   slot;
  logic [SEC_W-1:0]    end_sec;
  logic                do_seek;
  logic [SEC_W-1:0]    sk_sec_in, sk_sec;
  logic [OFFSET_W-1:0] sk_off_in, sk_off;
  logic                sk_wrap;
  logic [OFFSET_W:0]   off_plus_slot;
  logic                ok, blank, crc;
  logic                in_acc, out_acc, cfg_wr;
  logic [RECORD_W:0]   rec_round;

  assign ok    = in_tdata[0];
  assign blank = in_tdata[1];
  assign crc   = in_tdata[2];

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign rec_round = ({1'b0, record_r} + (RECORD_W+1)'(3)) & ~(RECORD_W+1)'(3);
  assign slot      = SLOT_W'(rec_round) + SLOT_W'(124);
  assign end_sec   = SEC_W'(first_r) + SEC_W'((count_r == '0) ? COUNT_W'(1) : count_r)
                     - SEC_W'(1);
  assign off_plus_slot = {1'b0, off_r} + (OFFSET_W+1)'(slot);

  always_comb begin
    if (in_tuser == OP_START) begin
      sk_sec_in = SEC_W'(first_r);
      sk_off_in = '0;
    end else if (in_tuser == OP_UPDATE) begin
      sk_sec_in = sec_r;
      sk_off_in = off_r;
    end else begin
      sk_sec_in = sec_r;
      sk_off_in = off_plus_slot[OFFSET_W-1:0];
    end
    if (sk_off_in >= OFFSET_W'(SECTOR_BYTES)) begin
      sk_sec = sk_sec_in + SEC_W'(1);
      sk_off = '0;
    end else begin
      sk_sec = sk_sec_in;
      sk_off = sk_off_in;
    end
    sk_wrap = sk_sec > end_sec;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    k         = '0;
    do_seek   = 1'b0;
    sec_nxt   = sec_r;
    off_nxt   = off_r;
    phase_nxt = phase_r;
    case (in_tuser)
      OP_START: begin
        phase_nxt = PH_SCAN;
        do_seek   = 1'b1;
      end
      OP_UPDATE: begin
        phase_nxt = PH_UPD;
        do_seek   = 1'b1;
      end
      OP_REPORT: begin
        case (phase_r)
          PH_SCAN: begin
            if (ok && blank) begin
              res[0]    = '{cmd: CMD_DONE, addr: '0};
              k         = 2'd1;
              phase_nxt = PH_IDLE;
            end else begin
              if (ok && crc) begin
                res[0] = '{cmd: CMD_TAKE, addr: slot_addr(sec_r, off_r)};
                k      = 2'd1;
              end
              do_seek = 1'b1;
            end
          end
          PH_UPD: begin
            if (ok && blank) begin
              if (off_plus_slot >= (OFFSET_W+1)'(SECTOR_BYTES) && sec_r < end_sec) begin
                res[0]    = '{cmd: CMD_READ, addr: slot_addr(sec_r + SEC_W'(1), '0)};
                k         = 2'd1;
                phase_nxt = PH_LOOK;
              end else begin
                res[0]    = '{cmd: CMD_WRITE, addr: slot_addr(sec_r, off_r)};
                k         = 2'd1;
                off_nxt   = off_plus_slot[OFFSET_W-1:0];
                phase_nxt = PH_IDLE;
              end
            end else if (ok && off_r == '0) begin
              res[0]    = '{cmd: CMD_ERASE, addr: ADDR_W'(sec_r)};
              res[1]    = '{cmd: CMD_WRITE, addr: slot_addr(sec_r, '0)};
              k         = 2'd2;
              off_nxt   = OFFSET_W'(slot);
              phase_nxt = PH_IDLE;
            end else begin
              do_seek = 1'b1;
            end
          end
          PH_LOOK: begin
            if (ok && !blank) begin
              res[0] = '{cmd: CMD_ERASE, addr: ADDR_W'(sec_r + SEC_W'(1))};
              k      = 2'd1;
            end
            res[k]    = '{cmd: CMD_WRITE, addr: slot_addr(sec_r, off_r)};
            k         = k + 2'd1;
            off_nxt   = off_plus_slot[OFFSET_W-1:0];
            phase_nxt = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (do_seek) begin
      if (sk_wrap) begin
        res[k]    = '{cmd: CMD_ERASE, addr: ADDR_W'(first_r)};
        res[k+1]  = '{cmd: CMD_WRITE, addr: slot_addr(SEC_W'(first_r), '0)};
        k         = k + 2'd2;
        sec_nxt   = SEC_W'(first_r);
        off_nxt   = OFFSET_W'(slot);
        phase_nxt = PH_IDLE;
      end else begin
        res[k]  = '{cmd: CMD_READ, addr: slot_addr(sk_sec, sk_off)};
        k       = k + 2'd1;
        sec_nxt = sk_sec;
        off_nxt = sk_off;
      end
    end
  end

  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tlast  = cnt_r == 2'd1;
  assign out_tuser  = q_r[0].cmd;
  assign out_tdata  = {2'b00, q_r[0].addr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      count_r  <= COUNT_W'(1);
      record_r <= RECORD_W'(4);
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FIRST:  first_r  <= cfg_pwdata[FIRST_W-1:0];
        REG_COUNT:  count_r  <= cfg_pwdata[COUNT_W-1:0];
        REG_RECORD: record_r <= cfg_pwdata[RECORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FIRST:  cfg_prdata = 32'(first_r);
      REG_COUNT:  cfg_prdata = 32'(count_r);
      REG_RECORD: cfg_prdata = 32'(record_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= '0;
      off_r   <= '0;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (in_acc) begin
      sec_r   <= sec_nxt;
      off_r   <= off_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= k;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r <= res;
    end else if (out_acc) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

  a_reserved_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_RESERVED) |=> !out_tvalid)
    else $error("reserved operation produced a command");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast && !(in_tvalid && in_tready)) |=> !out_tvalid)
    else $error("result queue not empty after final command");

  a_look_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LOOK) |-> (off_r < OFFSET_W'(SECTOR_BYTES)))
    else $error("look-ahead phase with offset beyond sector end");

  a_idle_no_report_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == OP_REPORT && phase_r == PH_IDLE) |=> !out_tvalid)
    else $error("report while idle produced a command");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash record rotation controller testbench
// Drives scan, update, slot-report and reserved transactions into the
// controller and checks every flash command against a cycle-free prediction
// of the ring position. The ring layout is changed over several register
// settings, and both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import flrc_pkg::*;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int PHASE_ITEMS   = 60;
  localparam int RANDOM_PHASES = 6;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            read_ok;
    logic            slot_blank;
    logic            crc_match;
  } slot_item_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } flash_cmd_t;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_tvalid   = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata    = '0;
  logic [OP_W-1:0]      in_tuser    = '0;
  logic                 out_tvalid;
  logic                 out_tready  = 1'b0;
  logic [23:0]          out_tdata;
  logic [CMD_W-1:0]     out_tuser;
  logic                 out_tlast;
  logic                 cfg_psel    = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite  = 1'b0;
  logic [PADDR_W-1:0]   cfg_paddr   = '0;
  logic [31:0]          cfg_pwdata  = '0;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  logic [FIRST_W-1:0]   ring_first   = '0;
  logic [COUNT_W-1:0]   ring_count   = 9'd1;
  logic [RECORD_W-1:0]  ring_record  = 12'd4;
  logic [SEC_W-1:0]     pos_sector   = '0;
  logic [OFFSET_W-1:0]  pos_offset   = '0;
  logic [PHASE_W-1:0]   search_phase = PH_IDLE;

  slot_item_t pending_items[$];
  slot_item_t next_item;
  flash_cmd_t step_cmds[$];
  flash_cmd_t expected_cmds[$];

  int  send_gap       = 0;
  int  hold_cycles    = 0;
  bit  no_idle        = 1'b0;
  int  error_count    = 0;
  int  cycle_count    = 0;
  int  inputs_taken   = 0;
  int  items_queued   = 0;
  int  settings_used  = 0;
  int  cmds_seen [8]  = '{default: 0};

  flash_record_rotation_controller i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic log_error(input string msg);
    $display("ERROR cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [12:0] slot_bytes();
    logic [12:0] rounded;
    rounded      = 13'(ring_record) + 13'd3;
    rounded[1:0] = 2'b00;
    return rounded + 13'd124;
  endfunction

  function automatic logic [SEC_W-1:0] ring_last();
    logic [SEC_W-1:0] span;
    span = (ring_count == '0) ? 11'd1 : 11'(ring_count);
    return 11'(ring_first) + span - 11'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] byte_addr(input logic [SEC_W-1:0] sector,
                                                  input logic [OFFSET_W-1:0] offset);
    logic [31:0] full;
    full = 32'(sector) * 32'(SECTOR_BYTES) + 32'(offset);
    return full[ADDR_W-1:0];
  endfunction

  function automatic void add_cmd(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr);
    if (step_cmds.size() < 3) begin
      step_cmds.push_back('{cmd: cmd, addr: addr, last: 1'b0});
    end
  endfunction

  function automatic void write_record();
    add_cmd(CMD_WRITE, byte_addr(pos_sector, pos_offset));
    pos_offset   = pos_offset + OFFSET_W'(slot_bytes());
    search_phase = PH_IDLE;
  endfunction

  function automatic void wrap_to_first();
    pos_sector = 11'(ring_first);
    pos_offset = '0;
    add_cmd(CMD_ERASE, 22'(pos_sector));
    write_record();
  endfunction

  function automatic void seek_slot();
    if (32'(pos_offset) >= 32'(SECTOR_BYTES)) begin
      pos_sector = pos_sector + 11'd1;
      pos_offset = '0;
    end
    if (pos_sector > ring_last()) begin
      wrap_to_first();
    end else begin
      add_cmd(CMD_READ, byte_addr(pos_sector, pos_offset));
    end
  endfunction

  function automatic void next_slot();
    pos_offset = pos_offset + OFFSET_W'(slot_bytes());
    seek_slot();
  endfunction

  function automatic void predict_commands(input logic [OP_W-1:0] op, input logic ok,
                                           input logic blank, input logic crc);
    step_cmds.delete();
    case (op)
      OP_START: begin
        pos_sector   = 11'(ring_first);
        pos_offset   = '0;
        search_phase = PH_SCAN;
        seek_slot();
      end
      OP_UPDATE: begin
        search_phase = PH_UPD;
        seek_slot();
      end
      OP_REPORT: begin
        case (search_phase)
          PH_SCAN: begin
            if (ok && blank) begin
              add_cmd(CMD_DONE, '0);
              search_phase = PH_IDLE;
            end else begin
              if (ok && crc) begin
                add_cmd(CMD_TAKE, byte_addr(pos_sector, pos_offset));
              end
              next_slot();
            end
          end
          PH_UPD: begin
            if (ok && blank) begin
              if (32'(pos_offset) + 32'(slot_bytes()) >= 32'(SECTOR_BYTES) &&
                  pos_sector < ring_last()) begin
                add_cmd(CMD_READ, byte_addr(pos_sector + 11'd1, '0));
                search_phase = PH_LOOK;
              end else begin
                write_record();
              end
            end else if (ok && pos_offset == '0) begin
              add_cmd(CMD_ERASE, 22'(pos_sector));
              write_record();
            end else begin
              next_slot();
            end
          end
          PH_LOOK: begin
            if (ok && !blank) begin
              add_cmd(CMD_ERASE, 22'(pos_sector + 11'd1));
            end
            write_record();
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (step_cmds.size() > 0) begin
      step_cmds[step_cmds.size() - 1].last = 1'b1;
    end
    foreach (step_cmds[i]) begin
      expected_cmds.push_back(step_cmds[i]);
    end
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 96) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 50);
  endfunction

  task automatic check_flash_cmd();
    flash_cmd_t want;
    cmds_seen[out_tuser]++;
    if (expected_cmds.size() == 0) begin
      log_error($sformatf("unexpected command %0d address %h", out_tuser, out_tdata));
    end else begin
      want = expected_cmds.pop_front();
      if (out_tuser !== want.cmd) begin
        log_error($sformatf("command %0d, expected %0d", out_tuser, want.cmd));
      end
      if (out_tdata !== 24'(want.addr)) begin
        log_error($sformatf("address %h, expected %h (command %0d)", out_tdata, want.addr,
                            want.cmd));
      end
      if (out_tlast !== want.last) begin
        log_error($sformatf("last flag %b, expected %b", out_tlast, want.last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_commands(in_tuser, in_tdata[0], in_tdata[1], in_tdata[2]);
        inputs_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items.pop_front();
          in_tuser  <= next_item.op;
          in_tdata  <= {5'b00000, next_item.crc_match, next_item.slot_blank, next_item.read_ok};
          in_tvalid <= 1'b1;
          send_gap  = pick_idle();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        check_flash_cmd();
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ((out_tvalid && out_tready) || $urandom_range(0, 9) == 0) begin
          hold_cycles = pick_idle();
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles.", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic void queue_item(input logic [OP_W-1:0] op, input logic ok,
                                     input logic blank, input logic crc);
    pending_items.push_back('{op: op, read_ok: ok, slot_blank: blank, crc_match: crc});
    items_queued++;
  endfunction

  function automatic void add_report(input int blank_pct);
    queue_item(OP_REPORT, $urandom_range(0, 9) != 0, $urandom_range(0, 99) < blank_pct,
               $urandom_range(0, 9) < 7);
  endfunction

  function automatic void add_sequence();
    int kind;
    int reps;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      queue_item(OP_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      reps = $urandom_range(1, 14);
      repeat (reps) add_report(8);
    end else if (kind < 85) begin
      queue_item(OP_UPDATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
      reps = $urandom_range(0, 3);
      repeat (reps) add_report(25);
      add_report(90);
      add_report(50);
    end else begin
      queue_item(OP_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endfunction

  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_items.size() != 0 || in_tvalid || expected_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_access(input logic [1:0] index, input logic write,
                            input logic [31:0] value, output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    rdata       = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_ring(input int first, input int count, input int record);
    logic [31:0] values [3];
    logic [31:0] rdata;
    wait_idle();
    values[REG_FIRST]  = 32'(first) & 32'h3FF;
    values[REG_COUNT]  = 32'(count) & 32'h1FF;
    values[REG_RECORD] = 32'(record) & 32'hFFF;
    for (int i = 0; i < 3; i++) begin
      cfg_access(2'(i), 1'b1, values[i], rdata);
    end
    ring_first  = values[REG_FIRST][FIRST_W-1:0];
    ring_count  = values[REG_COUNT][COUNT_W-1:0];
    ring_record = values[REG_RECORD][RECORD_W-1:0];
    for (int i = 0; i < 3; i++) begin
      cfg_access(2'(i), 1'b0, '0, rdata);
      if (rdata !== values[i]) begin
        log_error($sformatf("register %0d reads %h, expected %h", i, rdata, values[i]));
      end
    end
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    int count_pick;
    int record_pick;
    int phase_start;
    int chunk_start;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b1);
    queue_item(OP_RESERVED, 1'b1, 1'b0, 1'b1);
    queue_item(OP_START, 1'b0, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b0, 1'b1, 1'b1);
    queue_item(OP_REPORT, 1'b1, 1'b0, 1'b1);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b0);
    queue_item(OP_UPDATE, 1'b1, 1'b1, 1'b1);
    queue_item(OP_UPDATE, 1'b0, 1'b1, 1'b0);
    queue_item(OP_START, 1'b1, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b1);
    queue_item(OP_START, 1'b0, 1'b1, 1'b1);
    queue_item(OP_UPDATE, 1'b1, 1'b0, 1'b1);
    queue_item(OP_REPORT, 1'b1, 1'b0, 1'b0);

    set_ring(1023, 2, 3972);
    queue_item(OP_START, 1'b0, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b0, 1'b1);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b0);
    queue_item(OP_UPDATE, 1'b0, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b0);
    queue_item(OP_UPDATE, 1'b0, 1'b0, 1'b0);
    queue_item(OP_START, 1'b0, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b1);
    queue_item(OP_UPDATE, 1'b0, 1'b0, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b1, 1'b0);
    queue_item(OP_REPORT, 1'b1, 1'b0, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          set_ring(5, 0, 0);
        end
        1: begin
          set_ring(1023, 256, 4095);
        end
        2: begin
          set_ring(0, 1, 1);
        end
        default: begin
          count_pick  = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) :
                        $urandom_range(0, 256);
          record_pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 300) :
                        $urandom_range(300, 4095);
          set_ring($urandom_range(0, 1023), count_pick, record_pick);
        end
      endcase
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) begin
        no_idle     = ($urandom_range(0, 4) == 0);
        chunk_start = items_queued;
        while (items_queued - chunk_start < 20) begin
          add_sequence();
        end
        if ($urandom_range(0, 3) == 0) begin
          wait_idle();
        end else begin
          while (pending_items.size() > 4) begin
            @(negedge clk);
          end
        end
      end
    end

    wait_idle();
    $display("Covered %0d input transactions over %0d register settings.", inputs_taken,
             settings_used + 1);
    $display("Commands seen: read %0d, erase %0d, write %0d, take %0d, done %0d.",
             cmds_seen[CMD_READ], cmds_seen[CMD_ERASE], cmds_seen[CMD_WRITE],
             cmds_seen[CMD_TAKE], cmds_seen[CMD_DONE]);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
